// File: design/bgudc_pkg.sv
// ----------------------------------------------------------------------------
// bgudc_pkg
// Shared types, register indexes and the RGB lookup for the button gesture
// up/down counter.
// ----------------------------------------------------------------------------
package bgudc_pkg;

	localparam int unsigned CntW     = 3;
	localparam int unsigned LedW     = 4;
	localparam int unsigned TimerW   = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [TimerW-1:0] TimerMax = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_DCLICK_WINDOW = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_REPEAT        = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE      = 2'd3;

	// Register reset values.
	localparam logic [9:0]  DclickWindowRst = 10'd50;
	localparam logic [15:0] LongPressRst    = 16'd400;
	localparam logic [9:0]  RepeatRst       = 10'd40;
	localparam logic [7:0]  DebounceRst     = 8'd5;

	typedef struct packed {
		logic [9:0]  dclick_window;
		logic [15:0] long_press;
		logic [9:0]  repeat_ticks;
		logic [7:0]  debounce;
	} cfg_t;

	typedef struct packed {
		logic [LedW-1:0] led_pattern;
		logic [CntW-1:0] count_value;
		logic            counting_down;
		logic            auto_active;
	} result_t;

	// RGB pins for each count value; pins sit on bits 3..1.
	function automatic logic [LedW-1:0] rgb_lookup(input logic [CntW-1:0] cnt);
		logic [LedW-1:0] pat;
		begin
			case (cnt)
				3'd0: pat = 4'h0;
				3'd1: pat = 4'h8;
				3'd2: pat = 4'h4;
				3'd3: pat = 4'hC;
				3'd4: pat = 4'h2;
				3'd5: pat = 4'hA;
				3'd6: pat = 4'h6;
				3'd7: pat = 4'hE;
				default: pat = 4'h0;
			endcase
			return pat;
		end
	endfunction

endpackage

// File: design/bgudc_cfg.sv
// ----------------------------------------------------------------------------
// bgudc_cfg
// Configuration register file; every write is taken in the cycle it arrives.
// ----------------------------------------------------------------------------
module bgudc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bgudc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bgudc_pkg::CfgDataW-1:0]  cfg_data,
	output bgudc_pkg::cfg_t                 cfg
);

	bgudc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dclick_window <= bgudc_pkg::DclickWindowRst;
			cfg_q.long_press    <= bgudc_pkg::LongPressRst;
			cfg_q.repeat_ticks  <= bgudc_pkg::RepeatRst;
			cfg_q.debounce      <= bgudc_pkg::DebounceRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bgudc_pkg::CFG_DCLICK_WINDOW: cfg_q.dclick_window <= cfg_data[9:0];
				bgudc_pkg::CFG_LONG_PRESS:    cfg_q.long_press    <= cfg_data[15:0];
				bgudc_pkg::CFG_REPEAT:        cfg_q.repeat_ticks  <= cfg_data[9:0];
				bgudc_pkg::CFG_DEBOUNCE:      cfg_q.debounce      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: design/bgudc_core.sv
// ----------------------------------------------------------------------------
// bgudc_core
// Gesture state machine: debounce, hold, auto repeat and the counter itself.
// The state advances once per button sample; nxt shows the updated values.
// ----------------------------------------------------------------------------
module bgudc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic                pressed,
	input  bgudc_pkg::cfg_t     cfg,
	output bgudc_pkg::result_t  nxt
);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PRESS_DB = 3'd1,
		PH_HOLD     = 3'd2,
		PH_AUTO_HLD = 3'd3,
		PH_AUTO_DB  = 3'd4,
		PH_AUTO_FRE = 3'd5,
		PH_REL_DB   = 3'd6
	} phase_t;

	phase_t                              phase_q, phase_d;
	logic [bgudc_pkg::CntW-1:0]          count_q, count_d;
	logic                                down_q, down_d;
	logic                                auto_q, auto_d;
	logic [bgudc_pkg::TimerW-1:0]        timer_q, timer_d;
	logic [bgudc_pkg::TimerW-1:0]        since_q, since_d;
	logic [bgudc_pkg::TimerW-1:0]        timer_inc;
	logic [bgudc_pkg::CntW-1:0]          count_step;
	logic                                db_done;
	logic                                rep_hit;

	assign timer_inc  = (timer_q == bgudc_pkg::TimerMax) ? timer_q : timer_q + 16'd1;
	assign count_step = down_q ? count_q - 3'd1 : count_q + 3'd1;
	assign db_done    = timer_inc > {8'd0, cfg.debounce};
	assign rep_hit    = timer_inc >= {6'd0, cfg.repeat_ticks};

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		down_d  = down_q;
		auto_d  = auto_q;
		timer_d = timer_q;
		since_d = (since_q == bgudc_pkg::TimerMax) ? since_q : since_q + 16'd1;

		case (phase_q)
			PH_PRESS_DB, PH_AUTO_DB, PH_REL_DB: begin
				if (db_done) begin
					timer_d = '0;
					case (phase_q)
						PH_PRESS_DB: phase_d = PH_HOLD;
						PH_AUTO_DB:  phase_d = PH_AUTO_FRE;
						default:     phase_d = PH_IDLE;
					endcase
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_HOLD: begin
				if (pressed) begin
					if (timer_inc >= cfg.long_press) begin
						auto_d  = 1'b1;
						phase_d = PH_AUTO_HLD;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end else begin
					// Release of a short press ends a click.
					count_d = count_step;
					since_d = '0;
					phase_d = PH_REL_DB;
					timer_d = '0;
				end
			end
			PH_AUTO_HLD: begin
				if (pressed) begin
					if (rep_hit) begin
						count_d = count_step;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end else begin
					phase_d = PH_AUTO_DB;
					timer_d = '0;
				end
			end
			PH_AUTO_FRE: begin
				if (pressed) begin
					// This press leaves auto mode with no debounce.
					auto_d  = 1'b0;
					phase_d = PH_HOLD;
					timer_d = '0;
				end else if (rep_hit) begin
					count_d = count_step;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (pressed) begin
					if (since_d <= {6'd0, cfg.dclick_window}) begin
						down_d = ~down_q;
					end
					phase_d = PH_PRESS_DB;
					timer_d = '0;
				end
			end
		endcase
	end

	assign nxt.led_pattern   = bgudc_pkg::rgb_lookup(count_d);
	assign nxt.count_value   = count_d;
	assign nxt.counting_down = down_d;
	assign nxt.auto_active   = auto_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			down_q  <= 1'b0;
			auto_q  <= 1'b0;
			timer_q <= '0;
			since_q <= bgudc_pkg::TimerMax;
		end else if (step_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			down_q  <= down_d;
			auto_q  <= auto_d;
			timer_q <= timer_d;
			since_q <= since_d;
		end
	end

endmodule

// File: design/button_gesture_up_down_counter_unit.sv
// ----------------------------------------------------------------------------
// button_gesture_up_down_counter_unit
// Button gesture counter: debounced press/release, double-click direction
// reversal, long-press auto repeat, and a 3-bit counter shown on RGB pins.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   button_pressed
//   out       out_valid / out_stall led_pattern, count_value, counting_down,
//                                   auto_active
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One button sample is taken per cycle while in_stall is low; each yields one
// result via the input register, then the state update into the result
// register. The gesture state updates once per sample as it moves into the
// result register. Reset clears the valid flags and gesture state (not the
// data registers) and loads the register defaults. A stalled result holds;
// the input register still takes one more sample; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module button_gesture_up_down_counter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            button_pressed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bgudc_pkg::LedW-1:0]      led_pattern,
	output logic [bgudc_pkg::CntW-1:0]      count_value,
	output logic                            counting_down,
	output logic                            auto_active,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bgudc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bgudc_pkg::CfgDataW-1:0]  cfg_data
);

	bgudc_pkg::cfg_t    cfg;
	bgudc_pkg::result_t nxt;
	bgudc_pkg::result_t res_s2;
	logic               valid_s1;
	logic               button_s1;
	logic               valid_s2;
	logic               s2_free;
	logic               advance;

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	bgudc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgudc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.pressed (button_s1),
		.cfg     (cfg),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_pressed;
		end
		if (advance) begin
			res_s2 <= nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign led_pattern   = res_s2.led_pattern;
	assign count_value   = res_s2.count_value;
	assign counting_down = res_s2.counting_down;
	assign auto_active   = res_s2.auto_active;

endmodule

// File: design/bgudc_checker.sv
// ----------------------------------------------------------------------------
// bgudc_checker
// Port-level checks for the button gesture counter, bound to the top level.
// ----------------------------------------------------------------------------
module bgudc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [bgudc_pkg::LedW-1:0]      led_pattern,
	input logic [bgudc_pkg::CntW-1:0]      count_value
);

	logic [bgudc_pkg::CntW-1:0] last_cnt_q;
	logic                       out_xfer;

	assign out_xfer = out_valid && !out_stall;

	// Count carried by the last delivered result; the counter starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (out_xfer) begin
			last_cnt_q <= count_value;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count_value)
			&& $stable(led_pattern))
		else $error("stalled result changed");

	a_led_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> led_pattern[0] == 1'b0 && led_pattern[3] == count_value[0]
			&& led_pattern[2] == count_value[1] && led_pattern[1] == count_value[2])
		else $error("LED pattern does not match count");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> count_value == last_cnt_q || count_value == last_cnt_q + 3'd1
			|| count_value == last_cnt_q - 3'd1)
		else $error("count moved by more than one step per sample");

endmodule

bind button_gesture_up_down_counter_unit bgudc_checker u_bgudc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.led_pattern (led_pattern),
	.count_value (count_value)
);
